>>> hw/rtl/toi_pkg.sv
// Shared types, widths and constants of the time-of-impact block.
// No dependencies; every other file uses it by scoped names.
`timescale 1ns / 1ps

package toi_pkg;

	localparam int FRAC_BITS = 16;
	localparam int XW        = 32;
	localparam int MAG_W     = 32;
	localparam int TIME_W    = 31;
	localparam int EPS_W     = 17;
	localparam int DISC_W    = 2 * MAG_W;
	localparam int ROOT_W    = DISC_W / 2;
	localparam int SREM_W    = ROOT_W + 3;
	localparam int N_W       = MAG_W + 3;
	localparam int NUM_W     = N_W - 1 + FRAC_BITS;
	localparam int LIM_W     = TIME_W + MAG_W;
	localparam int QW        = TIME_W;
	localparam int DREM_W    = MAG_W;
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;

	localparam logic [TIME_W-1:0] TIME_STEP_RST    = TIME_W'(1092);
	localparam logic [EPS_W-1:0]  VEL_EPS_RST      = EPS_W'(1);
	localparam logic [EPS_W-1:0]  CONTACT_SLOP_RST = EPS_W'(655);

	typedef enum logic [1:0] {
		REG_TIME_STEP,
		REG_VEL_EPS,
		REG_CONTACT_SLOP
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_LIN,
		KIND_QUAD
	} kind_t;

	typedef struct packed {
		logic [TIME_W-1:0] time_step;
		logic [EPS_W-1:0]  velocity_epsilon;
		logic [EPS_W-1:0]  contact_slop;
	} cfg_t;

	typedef struct packed {
		kind_t                 kind;
		logic signed [XW-1:0]  v;
		logic                  a_neg;
		logic [MAG_W-1:0]      den;
		logic [LIM_W-1:0]      lim;
		logic [MAG_W-1:0]      xm;
	} sq_side_t;

	typedef struct packed {
		logic [DISC_W-1:0] n;
		logic [SREM_W-1:0] rem;
		logic [ROOT_W-1:0] root;
		sq_side_t          side;
	} sq_data_t;

	typedef struct packed {
		kind_t             kind;
		logic [QW-1:0]     num1;
		logic [QW-1:0]     num2;
		logic [DREM_W-1:0] rem1;
		logic [DREM_W-1:0] rem2;
		logic [QW-1:0]     q1;
		logic [QW-1:0]     q2;
		logic [MAG_W-1:0]  den;
		logic              h1;
		logic              h2;
	} dv_data_t;

	function automatic logic [MAG_W-1:0] mag(input logic signed [XW-1:0] val);
		return val[XW-1] ? MAG_W'(~val + XW'(1)) : MAG_W'(val);
	endfunction

endpackage

>>> hw/rtl/toi_if.sv
// Request and response channel interfaces of the time-of-impact block.
// Depends on toi_pkg for field widths.
`timescale 1ns / 1ps

interface toi_req_if;
	logic                          valid;
	logic                          ready;
	logic signed [toi_pkg::XW-1:0] rel_position;
	logic signed [toi_pkg::XW-1:0] rel_velocity;
	logic signed [toi_pkg::XW-1:0] accel;

	modport source(output valid, rel_position, rel_velocity, accel, input ready);
	modport sink(input valid, rel_position, rel_velocity, accel, output ready);
endinterface

interface toi_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         hit;
	logic [toi_pkg::TIME_W-1:0]   impact_time;

	modport source(output valid, hit, impact_time, input ready);
	modport sink(input valid, hit, impact_time, output ready);
endinterface

>>> hw/rtl/time_of_impact_1d.sv
// Time of impact within one step for a body under constant acceleration,
// Q16.16 in, unsigned Q15.16 time out. One transaction is accepted per clock
// while the output is not stalled, and each yields one result through 67 register stages:
// three front stages (products, discriminant), a chain of 32 square-root cells,
// a chain of 31 divider cells and the output register.
// Backpressure stalls only occupied cells, so bubbles close up while waiting.
// Depends on toi_pkg, toi_if, toi_regs, toi_front, toi_sqrt_cell, toi_div_cell.
`timescale 1ns / 1ps

module time_of_impact_1d (
	input  logic                        clk,
	input  logic                        arst_n,
	toi_req_if.sink                     req,
	toi_rsp_if.source                   rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [toi_pkg::ADDR_W-1:0]  paddr,
	input  logic [toi_pkg::DATA_W-1:0]  pwdata,
	output logic [toi_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	toi_pkg::cfg_t cfg;

	logic              sq_vld [0:toi_pkg::ROOT_W];
	logic              sq_rdy [0:toi_pkg::ROOT_W];
	toi_pkg::sq_data_t sq_dat [0:toi_pkg::ROOT_W];
	logic              dv_vld [0:toi_pkg::QW];
	logic              dv_rdy [0:toi_pkg::QW];
	toi_pkg::dv_data_t dv_dat [0:toi_pkg::QW];
	toi_pkg::dv_data_t dv_first;

	logic signed [toi_pkg::N_W-1:0] vx, sx, n1, n2;
	logic [toi_pkg::N_W-2:0]        nm1, nm2;
	logic [toi_pkg::NUM_W-1:0]      num1, num2;
	logic                           h1, h2;
	toi_pkg::sq_side_t              sd;

	logic                       rsp_valid_q, hit_q, rdy_out, hit_n;
	logic [toi_pkg::TIME_W-1:0] time_q, t_n;

	toi_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	toi_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.x        (req.rel_position),
		.v        (req.rel_velocity),
		.a        (req.accel),
		.out_valid(sq_vld[0]),
		.out_ready(sq_rdy[0]),
		.out_data (sq_dat[0])
	);

	for (genvar i = 0; i < toi_pkg::ROOT_W; i++) begin : g_sqrt
		toi_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (sq_vld[i]),
			.in_ready (sq_rdy[i]),
			.in_data  (sq_dat[i]),
			.out_valid(sq_vld[i+1]),
			.out_ready(sq_rdy[i+1]),
			.out_data (sq_dat[i+1])
		);
	end

	always_comb begin
		sd   = sq_dat[toi_pkg::ROOT_W].side;
		vx   = toi_pkg::N_W'(sd.v);
		sx   = signed'(toi_pkg::N_W'(sq_dat[toi_pkg::ROOT_W].root));
		n1   = sx - vx;
		n2   = -sx - vx;
		nm1  = (toi_pkg::N_W-1)'(n1[toi_pkg::N_W-1] ? -n1 : n1);
		nm2  = (toi_pkg::N_W-1)'(n2[toi_pkg::N_W-1] ? -n2 : n2);
		num1 = {nm1, toi_pkg::FRAC_BITS'(0)};
		num2 = {nm2, toi_pkg::FRAC_BITS'(0)};
		h1   = (n1 != '0) && (n1[toi_pkg::N_W-1] == sd.a_neg) &&
		       (toi_pkg::LIM_W'(num1) <= sd.lim);
		h2   = (n2 != '0) && (n2[toi_pkg::N_W-1] == sd.a_neg) &&
		       (toi_pkg::LIM_W'(num2) <= sd.lim);
		if (sd.kind == toi_pkg::KIND_LIN) begin
			num1 = toi_pkg::NUM_W'({sd.xm, toi_pkg::FRAC_BITS'(0)});
			h1   = 1'b1;
			h2   = 1'b0;
		end else if (sd.kind != toi_pkg::KIND_QUAD) begin
			h1 = 1'b0;
			h2 = 1'b0;
		end
		dv_first.kind = sd.kind;
		dv_first.den  = sd.den;
		dv_first.num1 = num1[toi_pkg::QW-1:0];
		dv_first.num2 = num2[toi_pkg::QW-1:0];
		dv_first.rem1 = toi_pkg::DREM_W'(num1[toi_pkg::NUM_W-1:toi_pkg::QW]);
		dv_first.rem2 = toi_pkg::DREM_W'(num2[toi_pkg::NUM_W-1:toi_pkg::QW]);
		dv_first.q1   = '0;
		dv_first.q2   = '0;
		dv_first.h1   = h1;
		dv_first.h2   = h2;
	end

	assign dv_dat[0]              = dv_first;
	assign dv_vld[0]              = sq_vld[toi_pkg::ROOT_W];
	assign sq_rdy[toi_pkg::ROOT_W] = dv_rdy[0];

	for (genvar j = 0; j < toi_pkg::QW; j++) begin : g_div
		toi_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (dv_vld[j]),
			.in_ready (dv_rdy[j]),
			.in_data  (dv_dat[j]),
			.out_valid(dv_vld[j+1]),
			.out_ready(dv_rdy[j+1]),
			.out_data (dv_dat[j+1])
		);
	end

	assign rdy_out            = !rsp_valid_q || rsp.ready;
	assign dv_rdy[toi_pkg::QW] = rdy_out;

	always_comb begin
		hit_n = dv_dat[toi_pkg::QW].h1 || dv_dat[toi_pkg::QW].h2;
		if (dv_dat[toi_pkg::QW].h1 && dv_dat[toi_pkg::QW].h2) begin
			t_n = (dv_dat[toi_pkg::QW].q1 < dv_dat[toi_pkg::QW].q2) ?
			      dv_dat[toi_pkg::QW].q1 : dv_dat[toi_pkg::QW].q2;
		end else if (dv_dat[toi_pkg::QW].h1) begin
			t_n = dv_dat[toi_pkg::QW].q1;
		end else if (dv_dat[toi_pkg::QW].h2) begin
			t_n = dv_dat[toi_pkg::QW].q2;
		end else begin
			t_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rdy_out) begin
			rsp_valid_q <= dv_vld[toi_pkg::QW];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && dv_vld[toi_pkg::QW]) begin
			hit_q  <= hit_n;
			time_q <= t_n;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.hit         = hit_q;
	assign rsp.impact_time = time_q;

	a_idle_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> rsp.valid)
		else $error("input stalled with empty output register");

	a_miss_zero_time: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.hit |-> rsp.impact_time == '0)
		else $error("miss carries nonzero time");

	a_none_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		dv_vld[toi_pkg::QW] && dv_dat[toi_pkg::QW].kind == toi_pkg::KIND_NONE
		|-> !dv_dat[toi_pkg::QW].h1 && !dv_dat[toi_pkg::QW].h2)
		else $error("hit flagged for a transaction without a root");

	a_lin_one_lane: assert property (@(posedge clk) disable iff (!arst_n)
		dv_vld[toi_pkg::QW] && dv_dat[toi_pkg::QW].kind == toi_pkg::KIND_LIN
		|-> dv_dat[toi_pkg::QW].h1 && !dv_dat[toi_pkg::QW].h2)
		else $error("linear root lanes inconsistent");
endmodule

>>> hw/rtl/toi_regs.sv
// APB configuration registers: time step, velocity epsilon, contact slop.
// Depends on toi_pkg.
`timescale 1ns / 1ps

module toi_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [toi_pkg::ADDR_W-1:0]   paddr,
	input  logic [toi_pkg::DATA_W-1:0]   pwdata,
	output logic [toi_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output toi_pkg::cfg_t                cfg
);
	toi_pkg::cfg_t     cfg_q;
	toi_pkg::reg_idx_t idx;

	assign idx    = toi_pkg::reg_idx_t'(paddr[toi_pkg::ADDR_W-1:2]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.time_step        <= toi_pkg::TIME_STEP_RST;
			cfg_q.velocity_epsilon <= toi_pkg::VEL_EPS_RST;
			cfg_q.contact_slop     <= toi_pkg::CONTACT_SLOP_RST;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				toi_pkg::REG_TIME_STEP: begin
					cfg_q.time_step <= pwdata[toi_pkg::TIME_W-1:0];
				end
				toi_pkg::REG_VEL_EPS: begin
					cfg_q.velocity_epsilon <= pwdata[toi_pkg::EPS_W-1:0];
				end
				toi_pkg::REG_CONTACT_SLOP: begin
					cfg_q.contact_slop <= pwdata[toi_pkg::EPS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			toi_pkg::REG_TIME_STEP:    prdata = toi_pkg::DATA_W'(cfg_q.time_step);
			toi_pkg::REG_VEL_EPS:      prdata = toi_pkg::DATA_W'(cfg_q.velocity_epsilon);
			toi_pkg::REG_CONTACT_SLOP: prdata = toi_pkg::DATA_W'(cfg_q.contact_slop);
			default:                   prdata = '0;
		endcase
	end
endmodule

>>> hw/rtl/toi_front.sv
// Front end: magnitudes, products, discriminant and case selection, three stages.
// Depends on toi_pkg.
`timescale 1ns / 1ps

module toi_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  toi_pkg::cfg_t                 cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [toi_pkg::XW-1:0] x,
	input  logic signed [toi_pkg::XW-1:0] v,
	input  logic signed [toi_pkg::XW-1:0] a,
	output logic                          out_valid,
	input  logic                          out_ready,
	output toi_pkg::sq_data_t             out_data
);
	logic rdy1, rdy2, rdy3;
	logic vld_s1, vld_s2, vld_s3;

	logic signed [toi_pkg::XW-1:0]  x_s1, v_s1, a_s1;
	logic [toi_pkg::MAG_W-1:0]      xm_s1, vm_s1, am_s1;

	logic [toi_pkg::DISC_W-1:0]     vv_s2, axp_s2;
	logic [toi_pkg::LIM_W-1:0]      llim_s2, qlim_s2;
	logic [toi_pkg::MAG_W-1:0]      xm_s2, vm_s2, am_s2;
	logic signed [toi_pkg::XW-1:0]  v_s2;
	logic a_neg_s2, rest_s2, alin_s2, lin_ok_s2, x0_s2, opp_s2, a_zero_s2, ax_pos_s2;

	logic [toi_pkg::DISC_W-1:0] vv, axp, ax2, disc;
	logic [toi_pkg::LIM_W-1:0]  llim, qlim, lin_num;
	logic rest, alin, lin_ok, x0, opp, ax_pos, ok;
	toi_pkg::kind_t    kind;
	toi_pkg::sq_data_t nxt, data_s3;

	assign rdy3     = !vld_s3 || out_ready;
	assign rdy2     = !vld_s2 || rdy3;
	assign rdy1     = !vld_s1 || rdy2;
	assign in_ready = rdy1;

	always_comb begin
		vv     = vm_s1 * vm_s1;
		axp    = am_s1 * xm_s1;
		llim   = cfg.time_step * vm_s1;
		qlim   = cfg.time_step * am_s1;
		rest   = (vm_s1 < toi_pkg::MAG_W'(cfg.velocity_epsilon)) &&
		         (xm_s1 < toi_pkg::MAG_W'(cfg.contact_slop));
		alin   = am_s1 < toi_pkg::MAG_W'(cfg.velocity_epsilon);
		lin_ok = (vm_s1 >= toi_pkg::MAG_W'(cfg.velocity_epsilon)) && (v_s1 != '0);
		x0     = x_s1 == '0;
		opp    = (!x_s1[toi_pkg::XW-1] && !x0) != (!v_s1[toi_pkg::XW-1] && v_s1 != '0);
		ax_pos = !x0 && ((!a_s1[toi_pkg::XW-1] && a_s1 != '0) == !x_s1[toi_pkg::XW-1]);
	end

	always_comb begin
		ax2     = {axp_s2[toi_pkg::DISC_W-2:0], 1'b0};
		ok      = !ax_pos_s2 || (ax2 <= vv_s2);
		disc    = ax_pos_s2 ? vv_s2 - ax2 : vv_s2 + ax2;
		lin_num = toi_pkg::LIM_W'({xm_s2, toi_pkg::FRAC_BITS'(0)});
		if (rest_s2) begin
			kind = toi_pkg::KIND_NONE;
		end else if (alin_s2) begin
			kind = (lin_ok_s2 && (x0_s2 || (opp_s2 && lin_num <= llim_s2))) ?
			       toi_pkg::KIND_LIN : toi_pkg::KIND_NONE;
		end else begin
			kind = (!a_zero_s2 && ok) ? toi_pkg::KIND_QUAD : toi_pkg::KIND_NONE;
		end
		nxt.n          = disc;
		nxt.rem        = '0;
		nxt.root       = '0;
		nxt.side.kind  = kind;
		nxt.side.v     = v_s2;
		nxt.side.a_neg = a_neg_s2;
		nxt.side.den   = alin_s2 ? vm_s2 : am_s2;
		nxt.side.lim   = qlim_s2;
		nxt.side.xm    = xm_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= in_valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			x_s1  <= x;
			v_s1  <= v;
			a_s1  <= a;
			xm_s1 <= toi_pkg::mag(x);
			vm_s1 <= toi_pkg::mag(v);
			am_s1 <= toi_pkg::mag(a);
		end
		if (rdy2 && vld_s1) begin
			vv_s2     <= vv;
			axp_s2    <= axp;
			llim_s2   <= llim;
			qlim_s2   <= qlim;
			xm_s2     <= xm_s1;
			vm_s2     <= vm_s1;
			am_s2     <= am_s1;
			v_s2      <= v_s1;
			a_neg_s2  <= a_s1[toi_pkg::XW-1];
			rest_s2   <= rest;
			alin_s2   <= alin;
			lin_ok_s2 <= lin_ok;
			x0_s2     <= x0;
			opp_s2    <= opp;
			a_zero_s2 <= a_s1 == '0;
			ax_pos_s2 <= ax_pos;
		end
		if (rdy3 && vld_s2) begin
			data_s3 <= nxt;
		end
	end

	assign out_valid = vld_s3;
	assign out_data  = data_s3;
endmodule

>>> hw/rtl/toi_sqrt_cell.sv
// One cell of the square root chain: resolves one root bit per transaction.
// Depends on toi_pkg.
`timescale 1ns / 1ps

module toi_sqrt_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  toi_pkg::sq_data_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output toi_pkg::sq_data_t out_data
);
	logic                       vld_q;
	toi_pkg::sq_data_t          dat_q, nxt;
	logic [toi_pkg::SREM_W-1:0] sh, trial;
	logic                       ge;

	assign in_ready = !vld_q || out_ready;

	always_comb begin
		sh       = {in_data.rem[toi_pkg::SREM_W-3:0], in_data.n[toi_pkg::DISC_W-1 -: 2]};
		trial    = toi_pkg::SREM_W'({in_data.root, 2'b01});
		ge       = sh >= trial;
		nxt      = in_data;
		nxt.n    = in_data.n << 2;
		nxt.rem  = ge ? sh - trial : sh;
		nxt.root = {in_data.root[toi_pkg::ROOT_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) dat_q <= nxt;
	end

	assign out_valid = vld_q;
	assign out_data  = dat_q;
endmodule

>>> hw/rtl/toi_div_cell.sv
// One cell of the divider chain: one quotient bit for each of two roots.
// Depends on toi_pkg.
`timescale 1ns / 1ps

module toi_div_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  toi_pkg::dv_data_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output toi_pkg::dv_data_t out_data
);
	logic                       vld_q;
	toi_pkg::dv_data_t          dat_q, nxt;
	logic [toi_pkg::DREM_W:0]   sh1, sh2, dx;
	logic                       ge1, ge2;

	assign in_ready = !vld_q || out_ready;

	always_comb begin
		dx       = {1'b0, in_data.den};
		sh1      = {in_data.rem1, in_data.num1[toi_pkg::QW-1]};
		sh2      = {in_data.rem2, in_data.num2[toi_pkg::QW-1]};
		ge1      = sh1 >= dx;
		ge2      = sh2 >= dx;
		nxt      = in_data;
		nxt.num1 = in_data.num1 << 1;
		nxt.num2 = in_data.num2 << 1;
		nxt.rem1 = toi_pkg::DREM_W'(ge1 ? sh1 - dx : sh1);
		nxt.rem2 = toi_pkg::DREM_W'(ge2 ? sh2 - dx : sh2);
		nxt.q1   = {in_data.q1[toi_pkg::QW-2:0], ge1};
		nxt.q2   = {in_data.q2[toi_pkg::QW-2:0], ge2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) dat_q <= nxt;
	end

	assign out_valid = vld_q;
	assign out_data  = dat_q;
endmodule
